FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define PRD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define PRD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: sv/prd_pkg.sv
// shared constants, types and tables of the pid step block
// no dependencies
package prd_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int WIN_W      = 5;
    localparam int DATA_W     = 32;
    localparam int DT_W       = 16;
    localparam logic [DT_W-1:0] DT_DEFAULT = 16'd655;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_INT_LIMIT = 3'd3,
        CFG_WIN_LEN   = 3'd4
    } t_cfg_idx;

    // slope denominator n*Sxx - Sx^2 = n^2 (n^2 - 1) / 12
    function automatic logic [12:0] f_slope_den(input logic [WIN_W-1:0] n);
        logic [12:0] v;
        case (n)
            5'd2:    v = 13'd1;
            5'd3:    v = 13'd6;
            5'd4:    v = 13'd20;
            5'd5:    v = 13'd50;
            5'd6:    v = 13'd105;
            5'd7:    v = 13'd196;
            5'd8:    v = 13'd336;
            5'd9:    v = 13'd540;
            5'd10:   v = 13'd825;
            5'd11:   v = 13'd1210;
            5'd12:   v = 13'd1716;
            5'd13:   v = 13'd2366;
            5'd14:   v = 13'd3185;
            5'd15:   v = 13'd4200;
            5'd16:   v = 13'd5440;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // sum of x over 1..n
    function automatic logic [9:0] f_sum_x(input logic [WIN_W-1:0] n);
        logic [9:0] p;
        p = 10'(n) * 10'(n + 5'd1);
        return p >> 1;
    endfunction

endpackage

FILE: sv/pid_regression_derivative.sv
// pid step block: integral, least-squares slope derivative and gain sum
// depends on prd_pkg; one shared 33x33 multiplier under a sequencer
//
//  channel   direction  signals                               content
//  s_axis    in         tvalid tready tdata[47:0] tuser[0]    error_in, time_step; cmd
//  m_axis    out        tvalid tready tdata[31:0]             drive
//  cfg       in         i_cfg_we i_cfg_idx i_cfg_data          register writes
//
// a control step without a slope fit goes from the integral update straight to the
// gain products; with a full window of n errors it runs n multiply-accumulate steps,
// the restoring divider and three gain products on the multiplier
// a clear goes straight to its result; one item is in work at a time, ready is low meanwhile
// reset is synchronous and clears state, history and configuration registers
// a finished result waits in the output register; the next item is taken once it is free or draining
module pid_regression_derivative
    import prd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,  // error_in[31:0], time_step[47:32]
    input  logic [0:0]         s_axis_tuser,  // cmd[0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,  // drive[31:0]
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MULI = 11'b00000000010,
        S_ACCI = 11'b00000000100,
        S_WIN  = 11'b00000001000,
        S_WEND = 11'b00000010000,
        S_DCHK = 11'b00000100000,
        S_DIV  = 11'b00001000000,
        S_DFIN = 11'b00010000000,
        S_DRV  = 11'b00100000000,
        S_DSUM = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_gain_p, r_gain_i, r_gain_d;
    logic [30:0]        r_ilim;
    logic [WIN_W-1:0]   r_wlen;

    // controller state
    logic signed [31:0] r_int;
    logic signed [31:0] r_hist [MAX_WINDOW];
    logic [WIN_W-1:0]   r_hcnt;

    // item registers
    logic signed [31:0] r_e;
    logic [DT_W-1:0]    r_dt;
    logic [WIN_W-1:0]   r_n;
    logic [WIN_W-1:0]   r_k;
    logic signed [9:0]  r_coef;
    logic signed [65:0] r_prod;
    logic               r_pv;
    logic signed [66:0] r_acc;
    logic [28:0]        r_b;
    logic [29:0]        r_rem;
    logic [30:0]        r_dvd;
    logic [30:0]        r_quo;
    logic [4:0]         r_divc;
    logic               r_neg, r_sat;
    logic signed [31:0] r_d;
    logic signed [31:0] r_res;
    logic               r_ovld;
    logic [31:0]        r_odata;

    logic               w_in_xfer;
    logic [WIN_W-1:0]   w_n_eff;
    logic signed [32:0] w_ma, w_mb;
    logic signed [32:0] w_inc;
    logic signed [34:0] w_isum, w_lim;
    logic signed [31:0] w_int_new;
    logic [WIN_W-1:0]   w_hc_clip, w_hc_new;
    logic [WIN_W-1:0]   w_hidx;
    logic signed [47:0] w_num;
    logic [47:0]        w_mag;
    logic [29:0]        w_trial;
    logic [29:0]        w_bext;
    logic signed [50:0] w_dsum;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovld || m_axis_tready);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    // effective window length
    always_comb begin
        if (r_wlen == '0) begin
            w_n_eff = WIN_W'(1);
        end else if (r_wlen > WIN_W'(MAX_WINDOW)) begin
            w_n_eff = WIN_W'(MAX_WINDOW);
        end else begin
            w_n_eff = r_wlen;
        end
    end

    // shared multiplier operand select
    assign w_hidx = r_n - r_k;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MULI: begin
                w_ma = 33'(r_e);
                w_mb = $signed({17'd0, r_dt});
            end
            S_WIN: begin
                w_ma = 33'(r_coef);
                w_mb = 33'(r_hist[w_hidx[3:0]]);
            end
            S_WEND: begin
                w_ma = $signed({20'd0, f_slope_den(r_n)});
                w_mb = $signed({17'd0, r_dt});
            end
            S_DRV: begin
                case (r_k[1:0])
                    2'd0: begin
                        w_ma = 33'(r_gain_p);
                        w_mb = 33'(r_e);
                    end
                    2'd1: begin
                        w_ma = 33'(r_gain_i);
                        w_mb = 33'(r_int);
                    end
                    default: begin
                        w_ma = 33'(r_gain_d);
                        w_mb = 33'(r_d);
                    end
                endcase
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // integral update with clamp or saturation
    assign w_inc  = r_prod[48:16];
    assign w_isum = 35'(r_int) + 35'(w_inc);
    assign w_lim  = $signed({4'd0, r_ilim});
    always_comb begin
        if (r_ilim != '0) begin
            if (w_isum > w_lim) begin
                w_int_new = 32'(w_lim);
            end else if (w_isum < -w_lim) begin
                w_int_new = 32'(-w_lim);
            end else begin
                w_int_new = 32'(w_isum);
            end
        end else if (w_isum > 35'sd2147483647) begin
            w_int_new = 32'sh7fffffff;
        end else if (w_isum < -35'sd2147483648) begin
            w_int_new = 32'sh80000000;
        end else begin
            w_int_new = 32'(w_isum);
        end
    end

    // history fill count
    assign w_hc_clip = (r_hcnt > r_n - WIN_W'(1)) ? r_n - WIN_W'(1) : r_hcnt;
    assign w_hc_new  = w_hc_clip + WIN_W'(1);

    // slope numerator magnitude and divider step
    assign w_num   = r_acc[47:0];
    assign w_mag   = w_num[47] ? 48'(-w_num) : 48'(w_num);
    assign w_bext  = {1'b0, r_b};
    assign w_trial = {r_rem[28:0], r_dvd[30]};
    assign w_dsum  = 51'(r_acc >>> 16);

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (r_pv) begin
            r_acc <= r_acc + 67'(r_prod);
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_ilim   <= '0;
            r_wlen   <= WIN_W'(1);
            r_int    <= '0;
            r_hcnt   <= '0;
            r_ovld   <= 1'b0;
            r_pv     <= 1'b0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P:    r_gain_p <= i_cfg_data;
                    CFG_GAIN_I:    r_gain_i <= i_cfg_data;
                    CFG_GAIN_D:    r_gain_d <= i_cfg_data;
                    CFG_INT_LIMIT: r_ilim   <= i_cfg_data[30:0];
                    CFG_WIN_LEN:   r_wlen   <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            // output register
            if (r_ovld && m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            // products of these states go into the accumulator
            r_pv <= (r_state == S_WIN) || (r_state == S_DRV);
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (s_axis_tuser[0]) begin
                            r_int  <= '0;
                            r_hcnt <= '0;
                            r_res  <= '0;
                            for (int i = 0; i < MAX_WINDOW; i++) begin
                                r_hist[i] <= '0;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_e     <= s_axis_tdata[31:0];
                            r_dt    <= (s_axis_tdata[47:32] == '0) ? DT_DEFAULT
                                                                  : s_axis_tdata[47:32];
                            r_n     <= w_n_eff;
                            r_state <= S_MULI;
                        end
                    end
                end
                S_MULI: begin
                    r_state <= S_ACCI;
                end
                S_ACCI: begin
                    r_int <= w_int_new;
                    for (int i = MAX_WINDOW - 1; i > 0; i--) begin
                        r_hist[i] <= r_hist[i-1];
                    end
                    r_hist[0] <= r_e;
                    r_hcnt    <= w_hc_new;
                    r_acc     <= '0;
                    r_coef    <= $signed({5'd0, r_n}) - $signed(f_sum_x(r_n));
                    if (r_n >= WIN_W'(2) && w_hc_new >= r_n) begin
                        r_k     <= WIN_W'(1);
                        r_state <= S_WIN;
                    end else begin
                        r_d     <= '0;
                        r_k     <= '0;
                        r_state <= S_DRV;
                    end
                end
                // one weighted error per cycle, oldest first
                S_WIN: begin
                    r_k    <= r_k + WIN_W'(1);
                    r_coef <= r_coef + $signed({5'd0, r_n});
                    if (r_k == r_n) begin
                        r_state <= S_WEND;
                    end
                end
                S_WEND: begin
                    r_state <= S_DCHK;
                end
                // divisor, sign and overflow of the slope quotient
                S_DCHK: begin
                    r_b     <= r_prod[28:0];
                    r_neg   <= w_num[47];
                    r_sat   <= w_mag >= {4'd0, r_prod[28:0], 15'd0};
                    r_rem   <= {1'b0, w_mag[43:15]};
                    r_dvd   <= {w_mag[14:0], 16'd0};
                    r_divc  <= 5'd30;
                    r_state <= S_DIV;
                end
                // restoring divider, one quotient bit per cycle
                S_DIV: begin
                    if (w_trial >= w_bext) begin
                        r_rem <= w_trial - w_bext;
                        r_quo <= {r_quo[29:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[29:0], 1'b0};
                    end
                    r_dvd  <= {r_dvd[29:0], 1'b0};
                    r_divc <= r_divc - 5'd1;
                    if (r_divc == '0) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    if (r_sat) begin
                        r_d <= r_neg ? 32'sh80000000 : 32'sh7fffffff;
                    end else if (r_neg) begin
                        r_d <= -$signed({1'b0, r_quo});
                    end else begin
                        r_d <= $signed({1'b0, r_quo});
                    end
                    r_acc   <= '0;
                    r_k     <= '0;
                    r_state <= S_DRV;
                end
                // three gain products into the accumulator
                S_DRV: begin
                    r_k  <= r_k + WIN_W'(1);
                    if (r_k == WIN_W'(2)) begin
                        r_state <= S_DSUM;
                    end
                end
                S_DSUM: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_ovld <= 1'b1;
                    if (r_k == '1) begin
                        r_odata <= r_res;
                    end else if (w_dsum > 51'sd2147483647) begin
                        r_odata <= 32'h7fffffff;
                    end else if (w_dsum < -51'sd2147483648) begin
                        r_odata <= 32'h80000000;
                    end else begin
                        r_odata <= 32'(w_dsum);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // clear answers zero
            if (r_state == S_IDLE && w_in_xfer && s_axis_tuser[0]) begin
                r_k <= '1;
            end
        end
    end

endmodule

FILE: sv/prd_checker.sv
// port-level checks of the pid step block, bound to its top level
// depends on prd_pkg and assert_macros.svh
`include "assert_macros.svh"

module prd_props
    import prd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // a stalled result stays offered
    `PRD_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    // one item at a time: ready drops after an input transfer
    `PRD_ASSERT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // input is taken only when the output register is free or draining
    `PRD_ASSERT(a_out_room, i_clk, i_rst_n, s_axis_tready |-> !m_axis_tvalid || m_axis_tready)

    // no result without an item in work
    `PRD_ASSERT(a_no_spurious, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))

endmodule

bind pid_regression_derivative prd_props u_prd_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
